### sv/lbbs_pkg.sv
// ---------------------------------------------------------------------------
// lbbs_pkg
// shared types, codes and reset values for the led blink and beeper sequencer
// ---------------------------------------------------------------------------
package lbbs_pkg;

    // request codes carried in req_type
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_LED_ON     = 3'd1;
    localparam logic [2:0] REQ_LED_OFF    = 3'd2;
    localparam logic [2:0] REQ_LED_BLINK  = 3'd3;
    localparam logic [2:0] REQ_BEEP_ON    = 3'd4;
    localparam logic [2:0] REQ_BEEP_OFF   = 3'd5;
    localparam logic [2:0] REQ_BEEP_DELAY = 3'd6;
    localparam logic [2:0] REQ_BEEP_COUNT = 3'd7;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BLINK_ON  = 2'd0;
    localparam logic [1:0] REG_BLINK_OFF = 2'd1;
    localparam logic [1:0] REG_BEEP_ON   = 2'd2;
    localparam logic [1:0] REG_BEEP_OFF  = 2'd3;

    // register reset values
    localparam logic [15:0] BLINK_ON_RESET  = 16'd50;
    localparam logic [15:0] BLINK_OFF_RESET = 16'd500;
    localparam logic [15:0] BEEP_ON_RESET   = 16'd100;
    localparam logic [15:0] BEEP_OFF_RESET  = 16'd200;

    // saturation value of the millisecond counters
    localparam logic [15:0] MS_SAT = 16'hFFFF;

    // led modes
    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ON    = 2'd1;
    localparam logic [1:0] LED_FLASH = 2'd2;

    // beeper modes
    localparam logic [2:0] BEEP_IDLE    = 3'd0;
    localparam logic [2:0] BEEP_ON      = 3'd1;
    localparam logic [2:0] BEEP_CNT_ON  = 3'd2;
    localparam logic [2:0] BEEP_CNT_OFF = 3'd3;
    localparam logic [2:0] BEEP_TIMED   = 3'd4;

    // last step of the phase recompute sweep (16 bits for each of two leds)
    localparam logic [4:0] DIV_LAST_STEP = 5'd31;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        led_select;
        logic [15:0] duration_ms;
        logic [7:0]  beep_count;
    } in_word_t;

    typedef struct packed {
        logic led_one_level;
        logic led_two_level;
        logic beep_enable;
    } out_word_t;

    // decoded per-led control for one accepted word
    typedef struct packed {
        logic tick;
        logic cmd_on;
        logic cmd_off;
        logic cmd_blink;
    } led_ctl_t;

    // decoded beeper control for one accepted word
    typedef struct packed {
        logic tick;
        logic cmd_on;
        logic cmd_off;
        logic cmd_delay;
        logic cmd_count;
    } beep_ctl_t;

    // phase write-back from the recompute unit
    typedef struct packed {
        logic        load_one;
        logic        load_two;
        logic [16:0] value;
    } phase_load_t;

endpackage

### sv/lbbs_led_channel.sv
// ---------------------------------------------------------------------------
// lbbs_led_channel
// one led: mode, blink timer and running blink phase
// ---------------------------------------------------------------------------
module lbbs_led_channel
    import lbbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  led_ctl_t    ctl,
    input  logic [15:0] duration,
    input  logic [15:0] blink_on,
    input  logic [16:0] period,
    input  logic        phase_load,
    input  logic [16:0] phase_value,
    output logic [15:0] elapsed,
    output logic        level_next
);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] limit_reg, limit_next;
    logic [16:0] phase_reg, phase_next;
    logic        level_reg;

    logic [15:0] elapsed_inc;
    logic [17:0] phase_inc;
    logic [16:0] phase_adv;

    // saturating millisecond count and phase kept equal to elapsed mod period
    always_comb
    begin
        elapsed_inc = (elapsed_reg == MS_SAT) ? elapsed_reg : elapsed_reg + 16'd1;
        phase_inc   = {1'b0, phase_reg} + 18'd1;
        if (elapsed_reg == MS_SAT)
        begin
            phase_adv = phase_reg;
        end
        else if ((period == 17'd0) || (phase_inc == {1'b0, period}))
        begin
            phase_adv = 17'd0;
        end
        else
        begin
            phase_adv = phase_inc[16:0];
        end
    end

    // next state for a tick or a command
    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        limit_next   = limit_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        if (phase_load)
        begin
            phase_next = phase_value;
        end
        if (ctl.tick)
        begin
            elapsed_next = elapsed_inc;
            phase_next   = phase_adv;
            unique case (mode_reg)
                LED_ON:
                begin
                    level_next = 1'b1;
                end
                LED_FLASH:
                begin
                    if (elapsed_inc >= limit_reg)
                    begin
                        mode_next = LED_OFF;
                    end
                    else
                    begin
                        level_next = (phase_adv <= {1'b0, blink_on});
                    end
                end
                default:
                begin
                    level_next = 1'b0;
                end
            endcase
        end
        else if (ctl.cmd_on)
        begin
            mode_next  = LED_ON;
            level_next = 1'b1;
        end
        else if (ctl.cmd_off)
        begin
            mode_next  = LED_OFF;
            level_next = 1'b0;
        end
        else if (ctl.cmd_blink)
        begin
            mode_next    = LED_FLASH;
            limit_next   = duration;
            elapsed_next = 16'd0;
            phase_next   = 17'd0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= LED_OFF;
            elapsed_reg <= 16'd0;
            limit_reg   <= 16'd0;
            phase_reg   <= 17'd0;
            level_reg   <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            limit_reg   <= limit_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
        end
    end

    assign elapsed = elapsed_reg;

endmodule

### sv/lbbs_beeper.sv
// ---------------------------------------------------------------------------
// lbbs_beeper
// beeper modes: on, off, delayed off and counted on/off phases
// ---------------------------------------------------------------------------
module lbbs_beeper
    import lbbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  beep_ctl_t   ctl,
    input  logic [15:0] duration,
    input  logic [7:0]  count,
    input  logic [15:0] beep_on,
    input  logic [15:0] silent_ms,
    output logic        enable_next
);

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] limit_reg, limit_next;
    logic [8:0]  phases_reg, phases_next;
    logic        enable_reg;

    logic [15:0] elapsed_inc;
    logic        more_phases;

    always_comb
    begin
        elapsed_inc = (elapsed_reg == MS_SAT) ? elapsed_reg : elapsed_reg + 16'd1;
        more_phases = (phases_reg > 9'd1);
    end

    // next state for a tick or a command
    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        limit_next   = limit_reg;
        phases_next  = phases_reg;
        enable_next  = enable_reg;
        if (ctl.tick)
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= limit_reg)
            begin
                unique case (mode_reg)
                    BEEP_TIMED:
                    begin
                        enable_next = 1'b0;
                        mode_next   = BEEP_IDLE;
                    end
                    BEEP_CNT_ON:
                    begin
                        enable_next = 1'b0;
                        if (more_phases)
                        begin
                            phases_next  = phases_reg - 9'd1;
                            elapsed_next = 16'd0;
                            limit_next   = silent_ms;
                            mode_next    = BEEP_CNT_OFF;
                        end
                        else
                        begin
                            phases_next = 9'd0;
                            mode_next   = BEEP_IDLE;
                        end
                    end
                    BEEP_CNT_OFF:
                    begin
                        if (more_phases)
                        begin
                            enable_next  = 1'b1;
                            phases_next  = phases_reg - 9'd1;
                            elapsed_next = 16'd0;
                            limit_next   = beep_on;
                            mode_next    = BEEP_CNT_ON;
                        end
                        else
                        begin
                            enable_next = 1'b0;
                            phases_next = 9'd0;
                            mode_next   = BEEP_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
        else if (ctl.cmd_on)
        begin
            enable_next = 1'b1;
            mode_next   = BEEP_ON;
        end
        else if (ctl.cmd_off)
        begin
            enable_next = 1'b0;
            mode_next   = BEEP_IDLE;
        end
        else if (ctl.cmd_delay)
        begin
            enable_next  = 1'b1;
            limit_next   = duration;
            elapsed_next = 16'd0;
            mode_next    = BEEP_TIMED;
        end
        else if (ctl.cmd_count)
        begin
            enable_next  = 1'b1;
            limit_next   = beep_on;
            phases_next  = {1'b0, count};
            elapsed_next = 16'd0;
            mode_next    = BEEP_CNT_ON;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= BEEP_IDLE;
            elapsed_reg <= 16'd0;
            limit_reg   <= 16'd0;
            phases_reg  <= 9'd0;
            enable_reg  <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            limit_reg   <= limit_next;
            phases_reg  <= phases_next;
            enable_reg  <= enable_next;
        end
    end

endmodule

### sv/lbbs_phase_div.sv
// ---------------------------------------------------------------------------
// lbbs_phase_div
// bit-serial remainder unit: rebuilds both blink phases after a period change
// ---------------------------------------------------------------------------
module lbbs_phase_div
    import lbbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] period,
    input  logic [15:0] elapsed_one,
    input  logic [15:0] elapsed_two,
    output phase_load_t load,
    output logic        busy
);

    logic        busy_reg;
    logic [4:0]  step_reg;
    logic [16:0] rem_reg;

    logic [15:0] dividend;
    logic [3:0]  bit_idx;
    logic [17:0] trial;
    logic [17:0] diff;
    logic [16:0] rem_step;
    logic        last_bit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        dividend = step_reg[4] ? elapsed_two : elapsed_one;
        bit_idx  = 4'd15 - step_reg[3:0];
        trial    = {rem_reg, dividend[bit_idx]};
        diff     = trial - {1'b0, period};
        rem_step = (trial >= {1'b0, period}) ? diff[16:0] : trial[16:0];
        last_bit = busy_reg && (step_reg[3:0] == 4'hF);
    end

    // write-back at the last bit of each led, zero phase for a zero period
    always_comb
    begin
        load.load_one = last_bit && !step_reg[4];
        load.load_two = last_bit && step_reg[4];
        load.value    = (period == 17'd0) ? 17'd0 : rem_step;
    end

    // sweep control, a new write restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 5'd0;
            rem_reg  <= 17'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 5'd0;
            rem_reg  <= 17'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            rem_reg  <= last_bit ? 17'd0 : rem_step;
            if (step_reg == DIV_LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;

endmodule

### sv/led_blink_and_beeper_sequencer.sv
// ---------------------------------------------------------------------------
// led_blink_and_beeper_sequencer
// two leds and a beeper sequenced by 1 ms ticks and commands
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one word: a 1 ms tick or an led or
//   beeper command. Every accepted word gives one out_data word with the
//   led levels and beeper enable as they stand after that word.
//   The result is registered: it sits in the output register on the
//   edge after acceptance. Throughput is one word per cycle while in_stall
//   is low; a new word is taken while the previous result is being read.
//   While out_stall holds a waiting result, in_stall is raised and the
//   result stays unchanged.
//   A write to the blink_on or blink_off register starts a bit-serial remainder
//   sweep that rebuilds both blink phases, 16 bits per led at one bit a
//   cycle; in_stall is high while the sweep runs. Beeper register writes
//   take effect at once.
//   Reset clears all modes, timers and levels, loads the register reset
//   values and empties the output register.
// ---------------------------------------------------------------------------
module led_blink_and_beeper_sequencer
    import lbbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] blink_on_reg, blink_off_reg, beep_on_reg, beep_off_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;

    logic        accept;
    logic        div_busy;
    logic        div_start;
    logic [16:0] period;
    phase_load_t phase_load;
    led_ctl_t    led_one_ctl, led_two_ctl;
    beep_ctl_t   beep_ctl;
    logic [15:0] elapsed_one, elapsed_two;
    logic        led_one_next, led_two_next, beep_next;
    logic        is_tick, is_led_on, is_led_off, is_led_blink;

    // handshake
    assign in_stall  = div_busy || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign period    = {1'b0, blink_on_reg} + {1'b0, blink_off_reg};
    assign div_start = cfg_write
                       && ((cfg_index == REG_BLINK_ON) || (cfg_index == REG_BLINK_OFF));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_reg  <= BLINK_ON_RESET;
            blink_off_reg <= BLINK_OFF_RESET;
            beep_on_reg   <= BEEP_ON_RESET;
            beep_off_reg  <= BEEP_OFF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLINK_ON:  blink_on_reg  <= cfg_data;
                REG_BLINK_OFF: blink_off_reg <= cfg_data;
                REG_BEEP_ON:   beep_on_reg   <= cfg_data;
                REG_BEEP_OFF:  beep_off_reg  <= cfg_data;
                default:       blink_on_reg  <= blink_on_reg;
            endcase
        end
    end

    // word decode
    always_comb
    begin
        is_tick      = accept && (in_data.req_type == REQ_TICK);
        is_led_on    = accept && (in_data.req_type == REQ_LED_ON);
        is_led_off   = accept && (in_data.req_type == REQ_LED_OFF);
        is_led_blink = accept && (in_data.req_type == REQ_LED_BLINK);

        led_one_ctl.tick      = is_tick;
        led_one_ctl.cmd_on    = is_led_on && !in_data.led_select;
        led_one_ctl.cmd_off   = is_led_off && !in_data.led_select;
        led_one_ctl.cmd_blink = is_led_blink && !in_data.led_select;

        led_two_ctl.tick      = is_tick;
        led_two_ctl.cmd_on    = is_led_on && in_data.led_select;
        led_two_ctl.cmd_off   = is_led_off && in_data.led_select;
        led_two_ctl.cmd_blink = is_led_blink && in_data.led_select;

        beep_ctl.tick      = is_tick;
        beep_ctl.cmd_on    = accept && (in_data.req_type == REQ_BEEP_ON);
        beep_ctl.cmd_off   = accept && (in_data.req_type == REQ_BEEP_OFF);
        beep_ctl.cmd_delay = accept && (in_data.req_type == REQ_BEEP_DELAY);
        beep_ctl.cmd_count = accept && (in_data.req_type == REQ_BEEP_COUNT);
    end

    lbbs_led_channel u_led_one (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (led_one_ctl),
        .duration    (in_data.duration_ms),
        .blink_on    (blink_on_reg),
        .period      (period),
        .phase_load  (phase_load.load_one),
        .phase_value (phase_load.value),
        .elapsed     (elapsed_one),
        .level_next  (led_one_next)
    );

    lbbs_led_channel u_led_two (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (led_two_ctl),
        .duration    (in_data.duration_ms),
        .blink_on    (blink_on_reg),
        .period      (period),
        .phase_load  (phase_load.load_two),
        .phase_value (phase_load.value),
        .elapsed     (elapsed_two),
        .level_next  (led_two_next)
    );

    lbbs_beeper u_beeper (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (beep_ctl),
        .duration    (in_data.duration_ms),
        .count       (in_data.beep_count),
        .beep_on     (beep_on_reg),
        .silent_ms   (beep_off_reg),
        .enable_next (beep_next)
    );

    lbbs_phase_div u_phase_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .period      (period),
        .elapsed_one (elapsed_one),
        .elapsed_two (elapsed_two),
        .load        (phase_load),
        .busy        (div_busy)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.led_one_level <= led_one_next;
            out_data_reg.led_two_level <= led_two_next;
            out_data_reg.beep_enable   <= beep_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### sv/lbbs_checker.sv
// ---------------------------------------------------------------------------
// lbbs_checker
// port-level checks for the led blink and beeper sequencer
// ---------------------------------------------------------------------------
module lbbs_checker
    import lbbs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input in_word_t    in_data,
    input logic        out_valid,
    input logic        out_stall,
    input out_word_t   out_data,
    input logic        cfg_write,
    input logic [1:0]  cfg_index
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every accepted word gives a result on the next edge
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word gave no result");

    // led one switched on shows lit
    a_led_one_on: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.req_type == REQ_LED_ON) && !in_data.led_select
        |=> out_data.led_one_level)
        else $error("led one not lit after on command");

    // beeper off command silences it
    a_beep_off: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.req_type == REQ_BEEP_OFF)
        |=> !out_data.beep_enable)
        else $error("beeper still enabled after off command");

    // a blink period write holds off input while phases are rebuilt
    a_period_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && ((cfg_index == REG_BLINK_ON) || (cfg_index == REG_BLINK_OFF))
        |=> in_stall)
        else $error("input taken during phase rebuild");

endmodule

bind led_blink_and_beeper_sequencer lbbs_checker u_lbbs_checker (.*);
